FILE: rtl/ashb_pkg.sv
// shared constants, codes and the command type of the sample history buffer
package ashb_pkg;

	localparam int CAPACITY = 4096;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY) + 1;
	localparam int MAX_READ = 64;
	localparam int RCNT_W   = 7;
	localparam int SMP_W    = 16;
	localparam int IDX_W    = 32;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		OP_PUSH        = 2'd0,
		OP_READ_ABS    = 2'd1,
		OP_READ_LATEST = 2'd2,
		OP_RESERVED    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_ERROR = 2'd2
	} cmd_kind_t;

	// one classified item on its way from the front to the back
	typedef struct packed {
		cmd_kind_t                kind;
		logic [ADDR_W-1:0]        addr;
		logic signed [SMP_W-1:0]  sample;
		logic [RCNT_W-1:0]        count;
		logic [CNT_W-1:0]         held;
		logic [IDX_W-1:0]         total;
		logic [IDX_W-1:0]         oldest;
	} cmd_t;

endpackage

FILE: rtl/ashb_chan_if.sv
// request and response channel interfaces of the sample history buffer
interface ashb_req_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         operation;
	logic signed [ashb_pkg::SMP_W-1:0]  in_sample;
	logic [ashb_pkg::IDX_W-1:0]         base_index;
	logic [ashb_pkg::RCNT_W-1:0]        read_count;

	modport source(output valid, operation, in_sample, base_index, read_count, input ready);
	modport sink(input valid, operation, in_sample, base_index, read_count, output ready);
endinterface

interface ashb_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               status;
	logic signed [ashb_pkg::SMP_W-1:0]  out_sample;
	logic                               last;
	logic [ashb_pkg::CNT_W-1:0]         held_count;
	logic [ashb_pkg::IDX_W-1:0]         total_written;
	logic [ashb_pkg::IDX_W-1:0]         oldest_index;

	modport source(output valid, status, out_sample, last, held_count, total_written,
		oldest_index, input ready);
	modport sink(input valid, status, out_sample, last, held_count, total_written,
		oldest_index, output ready);
endinterface

FILE: rtl/ashb_front.sv
// front end: accepts items, tracks fill and totals, classifies each item
module ashb_front (
	input  logic              clk,
	input  logic              arst_n,
	ashb_req_if.sink          request,
	output ashb_pkg::cmd_t    cmd,
	output logic              cmd_valid,
	input  logic              cmd_ready
);

	logic [ashb_pkg::CNT_W-1:0]  fill_q;
	logic [ashb_pkg::IDX_W-1:0]  total_q;
	logic [ashb_pkg::IDX_W-1:0]  oldest_q;

	logic [ashb_pkg::CNT_W-1:0]  fill_next;
	logic [ashb_pkg::IDX_W-1:0]  total_next;
	logic [ashb_pkg::IDX_W-1:0]  oldest_next;
	logic [ashb_pkg::IDX_W:0]    abs_end;
	logic                        bad_count;
	logic                        abs_err;
	logic                        lat_err;
	logic                        accept;

	assign request.ready = cmd_ready;
	assign cmd_valid     = request.valid;
	assign accept        = request.valid && cmd_ready;

	always_comb begin
		// state after a push
		total_next = total_q + ashb_pkg::IDX_W'(1);
		fill_next  = (fill_q < ashb_pkg::CNT_W'(ashb_pkg::CAPACITY)) ?
			fill_q + ashb_pkg::CNT_W'(1) : fill_q;
		oldest_next = (ashb_pkg::IDX_W'(fill_next) < total_next) ?
			total_next - ashb_pkg::IDX_W'(fill_next) : '0;

		bad_count = (request.read_count == '0) ||
			(request.read_count > ashb_pkg::RCNT_W'(ashb_pkg::MAX_READ));
		// end of range in 33 bits so the sum cannot wrap
		abs_end = {1'b0, request.base_index} + (ashb_pkg::IDX_W + 1)'(request.read_count);
		abs_err = bad_count || (request.base_index < oldest_q) ||
			(abs_end > {1'b0, total_q});
		// latest read starts at total - count; it only fails on count or a wrapped start
		lat_err = bad_count || (ashb_pkg::CNT_W'(request.read_count) > fill_q) ||
			(ashb_pkg::IDX_W'(request.read_count) > total_q);

		cmd        = '0;
		cmd.sample = request.in_sample;
		cmd.count  = request.read_count;
		cmd.held   = fill_q;
		cmd.total  = total_q;
		cmd.oldest = oldest_q;
		cmd.kind   = ashb_pkg::CMD_ERROR;
		case (ashb_pkg::op_t'(request.operation))
			ashb_pkg::OP_PUSH: begin
				cmd.kind   = ashb_pkg::CMD_PUSH;
				cmd.addr   = total_q[ashb_pkg::ADDR_W-1:0];
				cmd.held   = fill_next;
				cmd.total  = total_next;
				cmd.oldest = oldest_next;
			end
			ashb_pkg::OP_READ_ABS: begin
				cmd.kind = abs_err ? ashb_pkg::CMD_ERROR : ashb_pkg::CMD_READ;
				cmd.addr = request.base_index[ashb_pkg::ADDR_W-1:0];
			end
			ashb_pkg::OP_READ_LATEST: begin
				cmd.kind = lat_err ? ashb_pkg::CMD_ERROR : ashb_pkg::CMD_READ;
				cmd.addr = total_q[ashb_pkg::ADDR_W-1:0] -
					ashb_pkg::ADDR_W'(request.read_count);
			end
			default: begin
				cmd.kind = ashb_pkg::CMD_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			total_q  <= '0;
			oldest_q <= '0;
		end else if (accept && (ashb_pkg::op_t'(request.operation) == ashb_pkg::OP_PUSH)) begin
			fill_q   <= fill_next;
			total_q  <= total_next;
			oldest_q <= oldest_next;
		end
	end

endmodule

FILE: rtl/ashb_queue.sv
// short command queue between the front and the back
module ashb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  ashb_pkg::cmd_t    wr_cmd,
	input  logic              wr_valid,
	output logic              wr_ready,
	output ashb_pkg::cmd_t    rd_cmd,
	output logic              rd_valid,
	input  logic              rd_pop
);

	ashb_pkg::cmd_t              slot_q [ashb_pkg::QDEPTH];
	logic [ashb_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [ashb_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [ashb_pkg::QPTR_W:0]   level_q;
	logic                        do_wr;
	logic                        do_rd;

	assign wr_ready = (level_q != (ashb_pkg::QPTR_W + 1)'(ashb_pkg::QDEPTH));
	assign rd_valid = (level_q != '0);
	assign rd_cmd   = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + ashb_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + ashb_pkg::QPTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   level_q <= level_q + (ashb_pkg::QPTR_W + 1)'(1);
				2'b01:   level_q <= level_q - (ashb_pkg::QPTR_W + 1)'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

FILE: rtl/ashb_back.sv
// back end: sample memory, read sequencer and output register
module ashb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ashb_pkg::cmd_t    head,
	input  logic              head_valid,
	output logic              pop,
	ashb_rsp_if.source        response
);

	logic signed [ashb_pkg::SMP_W-1:0] mem [ashb_pkg::CAPACITY];

	logic [ashb_pkg::RCNT_W-1:0]       k_q;
	logic [ashb_pkg::RCNT_W-1:0]       k_next;
	logic [ashb_pkg::ADDR_W-1:0]       rd_addr;
	logic                              advance;
	logic                              issue;
	logic                              is_last;

	logic                              v_s1;
	logic                              status_s1;
	logic                              is_read_s1;
	logic                              last_s1;
	logic [ashb_pkg::CNT_W-1:0]        held_s1;
	logic [ashb_pkg::IDX_W-1:0]        total_s1;
	logic [ashb_pkg::IDX_W-1:0]        oldest_s1;
	logic signed [ashb_pkg::SMP_W-1:0] rdata_s1;

	assign advance = !v_s1 || response.ready;
	assign issue   = advance && head_valid;
	assign k_next  = k_q + ashb_pkg::RCNT_W'(1);
	assign is_last = (head.kind != ashb_pkg::CMD_READ) || (k_next == head.count);
	assign pop     = issue && is_last;
	assign rd_addr = head.addr + ashb_pkg::ADDR_W'(k_q);

	always_ff @(posedge clk) begin
		if (issue && (head.kind == ashb_pkg::CMD_PUSH)) begin
			mem[head.addr] <= head.sample;
		end
		if (issue && (head.kind == ashb_pkg::CMD_READ)) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			status_s1  <= (head.kind == ashb_pkg::CMD_ERROR);
			is_read_s1 <= (head.kind == ashb_pkg::CMD_READ);
			last_s1    <= is_last;
			held_s1    <= head.held;
			total_s1   <= head.total;
			oldest_s1  <= head.oldest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			k_q  <= '0;
		end else begin
			if (advance) begin
				v_s1 <= head_valid;
			end
			if (issue) begin
				k_q <= is_last ? '0 : k_next;
			end
		end
	end

	assign response.valid         = v_s1;
	assign response.status        = status_s1;
	assign response.out_sample    = is_read_s1 ? rdata_s1 : '0;
	assign response.last          = last_s1;
	assign response.held_count    = held_s1;
	assign response.total_written = total_s1;
	assign response.oldest_index  = oldest_s1;

endmodule

FILE: rtl/absolute_index_sample_history_buffer.sv
// top level of the overwriting sample history buffer with absolute indexing
// the first result of an item passes through the queue slot and then the output register;
// the back end yields one result for a push or an error and n results for a read of n samples,
// limited by the single read port of the sample memory; the four-entry queue absorbs bursts
// reset: fill count, total counter and oldest index clear at once; the sample memory
// keeps its contents and is not swept, entries are valid only once written
module absolute_index_sample_history_buffer (
	input  logic        clk,
	input  logic        arst_n,
	ashb_req_if.sink    request,
	ashb_rsp_if.source  response
);

	// classified commands from the front end
	ashb_pkg::cmd_t  fe_cmd;
	logic            fe_valid;
	logic            fe_ready;

	// head of the queue, seen by the back end
	ashb_pkg::cmd_t  q_head;
	logic            q_valid;
	logic            q_pop;

	// front end owns fill count and total, so range checks see every earlier push
	ashb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cmd       (fe_cmd),
		.cmd_valid (fe_valid),
		.cmd_ready (fe_ready)
	);

	// in-order queue keeps pushes ahead of the reads that follow them
	ashb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (fe_cmd),
		.wr_valid (fe_valid),
		.wr_ready (fe_ready),
		.rd_cmd   (q_head),
		.rd_valid (q_valid),
		.rd_pop   (q_pop)
	);

	// back end writes samples and streams reads, one result per cycle while the receiver is ready
	ashb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (q_valid),
		.pop        (q_pop),
		.response   (response)
	);

	// an error result is a single zero-sample item
	assert property (@(posedge clk) disable iff (!arst_n)
		response.valid && response.status |-> response.last && (response.out_sample == '0))
	else $error("error result not a single zero item");

	// until the store is full nothing has been overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		response.valid && (response.held_count < ashb_pkg::CNT_W'(ashb_pkg::CAPACITY))
		|-> (response.oldest_index == '0))
	else $error("oldest index nonzero before store is full");

	// oldest plus held gives the total whenever the total has not wrapped below it
	assert property (@(posedge clk) disable iff (!arst_n)
		response.valid && (response.total_written >= ashb_pkg::IDX_W'(response.held_count))
		|-> (response.oldest_index + ashb_pkg::IDX_W'(response.held_count)
			== response.total_written))
	else $error("oldest index inconsistent with held count and total");

	// a read stream stays valid and keeps the total written of its item
	assert property (@(posedge clk) disable iff (!arst_n)
		response.valid && response.ready && !response.last |=>
		response.valid && (response.total_written == $past(response.total_written)))
	else $error("read stream broken or status changed mid stream");

endmodule

FILE: test/tb_top.sv
// self-checking testbench for the overwriting sample history buffer with absolute indexing
`timescale 1ns / 1ps

module tb_top;
	import ashb_pkg::*;

	// one request item as the sender holds it
	typedef struct {
		op_t                      op;
		logic signed [SMP_W-1:0]  sample;
		logic [IDX_W-1:0]         start;
		logic [RCNT_W-1:0]        count;
	} sample_item_t;

	// one response item as the buffer should present it
	typedef struct {
		logic                     status;
		logic signed [SMP_W-1:0]  sample;
		logic                     last;
		logic [CNT_W-1:0]         held;
		logic [IDX_W-1:0]         total;
		logic [IDX_W-1:0]         oldest;
	} history_result_t;

	localparam int LONG_HOLD  = 300;
	localparam int BULK_PUSH  = 100;
	localparam int RAND_ITEMS = 150;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// request side and receiver ready, driven only through these variables
	logic                     req_valid  = 1'b0;
	logic [1:0]               req_op     = OP_PUSH;
	logic signed [SMP_W-1:0]  req_sample = '0;
	logic [IDX_W-1:0]         req_start  = '0;
	logic [RCNT_W-1:0]        req_count  = '0;
	logic                     rsp_ready  = 1'b0;

	ashb_req_if request_ch ();
	ashb_rsp_if response_ch ();

	assign request_ch.valid       = req_valid;
	assign request_ch.operation   = req_op;
	assign request_ch.in_sample   = req_sample;
	assign request_ch.base_index  = req_start;
	assign request_ch.read_count  = req_count;
	assign response_ch.ready      = rsp_ready;

	absolute_index_sample_history_buffer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request_ch),
		.response (response_ch)
	);

	// items waiting to be offered, and results waiting to be seen
	sample_item_t     pending_items[$];
	history_result_t  expected_results[$];
	sample_item_t     cur_item;

	// predicted contents of the buffer
	logic signed [SMP_W-1:0]  history_mem [CAPACITY];
	logic [ADDR_W-1:0]        wr_ptr_m = '0;
	logic [CNT_W-1:0]         held_m   = '0;
	logic [IDX_W-1:0]         total_m  = '0;

	// what the stimulus generator knows about fill level when it builds reads
	logic [IDX_W-1:0]  gen_total = '0;
	logic [CNT_W-1:0]  gen_fill  = '0;

	bit  idle_on       = 1'b1;
	int  hold_requests = 0;
	int  holds_done    = 0;
	int  hold_left     = 0;
	int  stall_left    = 0;
	int  gap_left      = 0;
	int  fail_count    = 0;
	int  n_pushes      = 0;
	int  n_reads       = 0;
	int  n_read_smp    = 0;
	int  n_errors      = 0;
	int  n_checked     = 0;

	// clock and the single reset at start of run
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// oldest absolute index still held, zero until the ring has wrapped
	function automatic logic [IDX_W-1:0] oldest_held();
		return (total_m > held_m) ? total_m - held_m : '0;
	endfunction

	function automatic void expect_result(logic st, logic signed [SMP_W-1:0] smp, logic lst);
		history_result_t r;
		r.status = st;
		r.sample = smp;
		r.last   = lst;
		r.held   = held_m;
		r.total  = total_m;
		r.oldest = oldest_held();
		expected_results.push_back(r);
	endfunction

	// advance the predicted state by one accepted item and queue its results
	function automatic void predict_history(sample_item_t it);
		logic [IDX_W-1:0]   first;
		logic [ADDR_W-1:0]  slot;
		bit                 ok;
		case (it.op)
			OP_PUSH: begin
				history_mem[wr_ptr_m] = it.sample;
				wr_ptr_m = wr_ptr_m + 1'b1;
				if (held_m < CAPACITY)
					held_m = held_m + 1'b1;
				total_m = total_m + 1'b1;
				expect_result(1'b0, '0, 1'b1);
				n_pushes++;
			end
			OP_READ_ABS, OP_READ_LATEST: begin
				// latest reads start count samples back from the write total
				first = (it.op == OP_READ_LATEST) ? total_m - it.count : it.start;
				ok = (it.count != 0) && (it.count <= MAX_READ) && (first >= oldest_held());
				// the end check is done one bit wider so start plus count cannot wrap
				if (({1'b0, first} + it.count) > {1'b0, total_m})
					ok = 1'b0;
				if (it.op == OP_READ_LATEST && it.count > held_m)
					ok = 1'b0;
				if (ok) begin
					slot = first[ADDR_W-1:0];
					for (int k = 0; k < it.count; k++) begin
						expect_result(1'b0, history_mem[slot], k == it.count - 1);
						slot = slot + 1'b1;
					end
					n_reads++;
					n_read_smp += it.count;
				end else begin
					expect_result(1'b1, '0, 1'b1);
					n_errors++;
				end
			end
			default: begin
				expect_result(1'b1, '0, 1'b1);
				n_errors++;
			end
		endcase
	endfunction

	// sender: offers queued items, with a random gap before each next one while idle_on is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap_left  <= 0;
		end else begin
			if (req_valid && request_ch.ready)
				predict_history(cur_item);
			if (!req_valid || request_ch.ready) begin
				if (gap_left != 0) begin
					gap_left  <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					cur_item   = pending_items.pop_front();
					req_op     <= cur_item.op;
					req_sample <= cur_item.sample;
					req_start  <= cur_item.start;
					req_count  <= cur_item.count;
					req_valid  <= 1'b1;
					gap_left   <= idle_on ? $urandom_range(0, 3) : 0;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready: short random stalls per item, plus long holds on request
	always @(posedge clk or negedge arst_n) begin
		int draw;
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= (hold_left == 1);
		end else if (holds_done < hold_requests) begin
			// long hold-off so the internal queue fills and back-pressures the sender
			holds_done <= holds_done + 1;
			hold_left  <= LONG_HOLD;
			rsp_ready  <= 1'b0;
		end else if (response_ch.valid && rsp_ready) begin
			draw = idle_on ? $urandom_range(0, 3) : 0;
			stall_left <= draw;
			rsp_ready  <= (draw == 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ready  <= (stall_left == 1);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	task automatic check_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// monitor: every accepted result against the oldest expectation
	always @(posedge clk) begin
		history_result_t want;
		if (arst_n && response_ch.valid && rsp_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0h sample %0h last %0h",
					response_ch.status, response_ch.out_sample, response_ch.last);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", IDX_W'(want.status), IDX_W'(response_ch.status));
				check_field("out_sample", IDX_W'(want.sample),
					IDX_W'(response_ch.out_sample));
				check_field("last", IDX_W'(want.last), IDX_W'(response_ch.last));
				check_field("held_count", IDX_W'(want.held), IDX_W'(response_ch.held_count));
				check_field("total_written", want.total, response_ch.total_written);
				check_field("oldest_index", want.oldest, response_ch.oldest_index);
				n_checked++;
			end
		end
	end

	// queue one item and track the fill level the generator will see
	task automatic add_item(op_t op, logic [SMP_W-1:0] smp, logic [IDX_W-1:0] start,
		logic [RCNT_W-1:0] count);
		sample_item_t it;
		it.op     = op;
		it.sample = smp;
		it.start  = start;
		it.count  = count;
		pending_items.push_back(it);
		if (op == OP_PUSH) begin
			gen_total = gen_total + 1'b1;
			if (gen_fill < CAPACITY)
				gen_fill = gen_fill + 1'b1;
		end
	endtask

	// mostly well-formed traffic, some reads just off either end, some noise
	task automatic add_random_item(int push_pct);
		int unsigned       roll;
		int unsigned       cnt;
		logic [IDX_W-1:0]  oldest;
		logic [IDX_W-1:0]  start;
		roll   = $urandom_range(0, 99);
		oldest = (gen_total > gen_fill) ? gen_total - gen_fill : '0;
		if (roll < push_pct || gen_fill == 0) begin
			add_item(OP_PUSH, SMP_W'($urandom), $urandom, RCNT_W'($urandom_range(0, 127)));
		end else if (roll < 88) begin
			// mostly short reads, now and then up to the longest allowed
			cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_READ) : $urandom_range(1, 8);
			if (cnt > gen_fill)
				cnt = {19'd0, gen_fill};
			if ($urandom_range(0, 1)) begin
				add_item(OP_READ_LATEST, SMP_W'($urandom), $urandom, RCNT_W'(cnt));
			end else begin
				case ($urandom_range(0, 3))
					0: start = oldest;
					1: start = gen_total - cnt;
					default: start = oldest + $urandom_range(0, gen_fill - cnt);
				endcase
				add_item(OP_READ_ABS, SMP_W'($urandom), start, RCNT_W'(cnt));
			end
		end else if (roll < 94) begin
			cnt = $urandom_range(1, 8);
			case ($urandom_range(0, 2))
				0: start = (oldest != 0) ? oldest - 1 : gen_total - cnt + 1;
				1: start = gen_total - cnt + 1;
				default: start = '0;
			endcase
			if (start == 0 && oldest == 0)
				add_item(OP_READ_LATEST, SMP_W'($urandom), $urandom,
					RCNT_W'(gen_fill + 1'b1));
			else
				add_item(OP_READ_ABS, SMP_W'($urandom), start, RCNT_W'(cnt));
		end else begin
			add_item(op_t'($urandom_range(0, 3)), SMP_W'($urandom), $urandom,
				RCNT_W'($urandom_range(0, 127)));
		end
	endtask

	// sender pause: nothing left to offer and every expected result seen
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
	endtask

	// stimulus phases
	initial begin
		// directed: empty buffer, sample extremes, count limits, range edges
		add_item(OP_READ_LATEST, '0, '0, 7'd1);
		add_item(OP_READ_ABS, '0, '0, 7'd1);
		add_item(OP_PUSH, 16'h7fff, '0, '0);
		add_item(OP_PUSH, 16'h8000, '1, '1);
		add_item(OP_PUSH, 16'h0000, '0, '0);
		add_item(OP_PUSH, 16'hffff, '0, '0);
		add_item(OP_PUSH, 16'h5555, '0, '0);
		add_item(OP_PUSH, 16'haaaa, '0, '0);
		add_item(OP_READ_ABS, '0, '0, 7'd6);
		add_item(OP_READ_LATEST, '0, '0, 7'd6);
		add_item(OP_READ_LATEST, '0, '0, 7'd7);
		add_item(OP_READ_ABS, '0, '0, 7'd0);
		add_item(OP_READ_LATEST, '0, '0, 7'd0);
		add_item(OP_READ_ABS, '0, '0, RCNT_W'(MAX_READ));
		add_item(OP_READ_ABS, '0, '0, RCNT_W'(MAX_READ + 1));
		add_item(OP_READ_ABS, '0, '0, 7'd127);
		add_item(OP_READ_LATEST, '0, '0, 7'd127);
		add_item(OP_READ_ABS, '0, 32'd5, 7'd1);
		add_item(OP_READ_ABS, '0, 32'd6, 7'd1);
		// start plus count wraps a 32-bit sum back into the held range
		add_item(OP_READ_ABS, '0, 32'hffff_fffa, 7'd6);
		add_item(OP_READ_ABS, '0, 32'hffff_ffc0, RCNT_W'(MAX_READ));
		add_item(OP_READ_ABS, '0, 32'hffff_ffff, 7'd1);
		add_item(OP_RESERVED, 16'hffff, '1, '1);
		add_item(OP_RESERVED, '0, '0, '0);
		wait_drained();

		// random traffic while the ring is still filling
		repeat (RAND_ITEMS) add_random_item(55);
		wait_drained();

		// back-to-back pushes, receiver held off at the start
		idle_on = 1'b0;
		hold_requests++;
		repeat (BULK_PUSH) add_item(OP_PUSH, SMP_W'($urandom), $urandom,
			RCNT_W'($urandom_range(0, 127)));
		wait_drained();

		// random traffic again, with another long receiver hold at the start
		idle_on = 1'b1;
		hold_requests++;
		repeat (RAND_ITEMS) add_random_item(40);
		wait_drained();

		repeat (20) @(negedge clk);
		$display("tb: %0d pushes, %0d good reads (%0d samples), %0d error results",
			n_pushes, n_reads, n_read_smp, n_errors);
		$display("tb: %0d results checked, final fill %0d, %0d long receiver holds",
			n_checked, held_m, holds_done);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// hard limit well beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: absolute_index_sample_history_buffer.f
rtl/ashb_pkg.sv
rtl/ashb_chan_if.sv
rtl/ashb_front.sv
rtl/ashb_queue.sv
rtl/ashb_back.sv
rtl/absolute_index_sample_history_buffer.sv
test/tb_top.sv
